// ===== src/kpg_pkg.sv =====
// shared types, codes and constants of the k-permutation generator
package kpg_pkg;

    localparam int RESULT_LIMIT         = 32;
    localparam int POS_W                = 5;
    localparam int PICK_W               = 6;
    localparam int CFG_W                = 6;
    localparam int CFG_IDX_W            = 1;
    localparam int REQ_W                = 2;
    localparam int LIDX_W               = 5;
    localparam int LVAL_W               = 8;
    localparam int SYM_OUT_W            = 8;
    localparam int CNT_W                = 32;
    localparam int DEF_MAX_ELEMENTS     = 32;
    localparam int DEF_SYMBOL_BITS      = 8;

    localparam logic [CFG_W-1:0] ELEM_RESET = 6'd26;
    localparam logic [CFG_W-1:0] PICK_RESET = 6'd5;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_LENGTH   = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [LIDX_W-1:0] index;
        logic [LVAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_qstat;

endpackage

// ===== src/kpg_front.sv =====
// front end: configuration registers, request classification and clamping
module kpg_front #(
    parameter int MAX_ELEMENTS = kpg_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [kpg_pkg::REQ_W-1:0]      i_req_type,
    input  logic [kpg_pkg::LIDX_W-1:0]     i_load_index,
    input  logic [kpg_pkg::LVAL_W-1:0]     i_load_value,
    input  logic                           i_cfg_valid,
    input  logic [kpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kpg_pkg::CFG_W-1:0]      i_cfg_data,
    input  kpg_pkg::t_qstat                i_qstat,
    output logic                           o_push,
    output kpg_pkg::t_req                  o_req,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0] o_run_n,
    output logic [kpg_pkg::PICK_W-1:0]     o_run_pick
);

    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam int TW = NW + kpg_pkg::CFG_W;

    logic [kpg_pkg::CFG_W-1:0] r_element_count;
    logic [kpg_pkg::CFG_W-1:0] r_pick_length;
    logic [TW-1:0]             e_ext;
    logic [TW-1:0]             n_ext;
    logic [TW-1:0]             k_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= kpg_pkg::ELEM_RESET;
            r_pick_length   <= kpg_pkg::PICK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kpg_pkg::CFG_ELEMENT_COUNT: r_element_count <= i_cfg_data;
                kpg_pkg::CFG_PICK_LENGTH:   r_pick_length   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective set size and selection length
    always_comb begin
        e_ext = TW'(r_element_count);
        if (e_ext == '0) begin
            n_ext = TW'(1);
        end else if (e_ext > TW'(MAX_ELEMENTS)) begin
            n_ext = TW'(MAX_ELEMENTS);
        end else begin
            n_ext = e_ext;
        end
        k_ext = TW'(r_pick_length);
        if (k_ext == '0) begin
            k_ext = TW'(1);
        end
        if (k_ext > n_ext) begin
            k_ext = n_ext;
        end
        if (k_ext > TW'(kpg_pkg::RESULT_LIMIT)) begin
            k_ext = TW'(kpg_pkg::RESULT_LIMIT);
        end
    end

    assign o_run_n    = NW'(n_ext);
    assign o_run_pick = kpg_pkg::PICK_W'(k_ext);

    assign o_req.kind  = i_req_type;
    assign o_req.index = i_load_index;
    assign o_req.value = i_load_value;

    // unused request code is taken and dropped here
    assign o_push = start && !i_qstat.full &&
                    (i_req_type inside {kpg_pkg::REQ_LOAD, kpg_pkg::REQ_RESTART,
                                        kpg_pkg::REQ_NEXT});

endmodule

// ===== src/kpg_queue.sv =====
// two-entry request queue between front and back
module kpg_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output kpg_pkg::t_qstat  o_qstat
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full     = (r_cnt == 2'd2);
    assign o_qstat.nonempty = (r_cnt != 2'd0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && o_qstat.nonempty;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/kpg_back.sv =====
// back end: symbol and working-set memories, digit counter, selection sequencer
module kpg_back #(
    parameter int MAX_ELEMENTS = kpg_pkg::DEF_MAX_ELEMENTS,
    parameter int SYMBOL_BITS  = kpg_pkg::DEF_SYMBOL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kpg_pkg::t_qstat                   i_qstat,
    input  kpg_pkg::t_req                     i_req,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0] i_run_n,
    input  logic [kpg_pkg::PICK_W-1:0]        i_run_pick,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic [kpg_pkg::SYM_OUT_W-1:0]     o_symbol,
    output logic                              o_last,
    output logic                              o_exhausted,
    output logic [kpg_pkg::CNT_W-1:0]         o_produced_count
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam int SW = NW + kpg_pkg::POS_W + 1;
    localparam int PW = kpg_pkg::POS_W;
    localparam int DN = kpg_pkg::RESULT_LIMIT;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]                 r_state;
    logic [NW-1:0]              r_n;
    logic [kpg_pkg::PICK_W-1:0] r_k;
    logic [PW-1:0]              r_p;
    logic                       r_carry;
    logic                       r_started;
    logic                       r_exhausted;
    logic [kpg_pkg::CNT_W-1:0]  r_count;
    logic [IW-1:0]              r_digit [DN];
    logic [MAX_ELEMENTS-1:0]    r_wvalid;
    logic [IW-1:0]              r_idx;
    logic [IW-1:0]              r_tail;

    logic [SYMBOL_BITS-1:0]     r_ss [MAX_ELEMENTS];
    logic [SYMBOL_BITS-1:0]     r_ws [MAX_ELEMENTS];
    logic [SYMBOL_BITS-1:0]     r_ss_qa;
    logic [SYMBOL_BITS-1:0]     r_ss_qb;
    logic [SYMBOL_BITS-1:0]     r_ws_qa;
    logic [SYMBOL_BITS-1:0]     r_ws_qb;

    logic                          r_out_valid;
    logic [kpg_pkg::SYM_OUT_W-1:0] r_out_sym;
    logic                          r_out_last;
    logic                          r_out_exh;
    logic [kpg_pkg::CNT_W-1:0]     r_out_cnt;

    logic [NW-1:0]          tail_full;
    logic [NW-1:0]          idx_full;
    logic [IW-1:0]          dig;
    logic [IW-1:0]          rd_a;
    logic [IW-1:0]          rd_b;
    logic [DN-1:0]          mx;
    logic [SW-1:0]          d1;
    logic                   wrap;
    logic                   at_last;
    logic                   take;
    logic                   emit_dead;
    logic                   emit_sym;
    logic                   ss_we;
    logic                   ws_we;
    logic [63:0]            load_wide;
    logic [SYMBOL_BITS-1:0] sym_sel;
    logic [SYMBOL_BITS-1:0] tail_sel;
    logic [63:0]            sym_wide;
    logic [kpg_pkg::CNT_W-1:0] count_inc;

    assign take  = (r_state == ST_IDLE) && i_qstat.nonempty;
    assign o_pop = take;

    // position addressing
    assign dig       = r_digit[r_p];
    assign tail_full = r_n - NW'(1) - NW'(r_p);
    assign idx_full  = (NW'(dig) > tail_full) ? tail_full : NW'(dig);
    assign rd_a      = IW'(idx_full);
    assign rd_b      = IW'(tail_full);
    assign at_last   = ((kpg_pkg::PICK_W'(r_p) + kpg_pkg::PICK_W'(1)) == r_k);

    // digit increment with carry
    assign d1   = SW'(dig) + SW'(1);
    assign wrap = (d1 + SW'(r_p)) >= SW'(r_n);

    // every active digit at its top value: the coming increment carries out
    always_comb begin
        for (int j = 0; j < DN; j++) begin
            mx[j] = (kpg_pkg::PICK_W'(j) >= r_k) ||
                    ((SW'(r_digit[j]) + SW'(j) + SW'(1)) >= SW'(r_n));
        end
    end

    assign count_inc = (r_count == '1) ? r_count : r_count + kpg_pkg::CNT_W'(1);

    assign emit_dead = take && (i_req.kind == kpg_pkg::REQ_NEXT) &&
                       (!r_started || r_exhausted);
    assign emit_sym  = (r_state == ST_WRITE);

    assign ss_we     = take && (i_req.kind == kpg_pkg::REQ_LOAD) &&
                       (32'(i_req.index) < MAX_ELEMENTS);
    assign ws_we     = emit_sym;
    assign load_wide = 64'(i_req.value);

    assign sym_sel  = r_wvalid[r_idx]  ? r_ws_qa : r_ss_qa;
    assign tail_sel = r_wvalid[r_tail] ? r_ws_qb : r_ss_qb;
    assign sym_wide = 64'(sym_sel);

    always_ff @(posedge i_clk) begin
        if (ss_we) begin
            r_ss[IW'(i_req.index)] <= load_wide[SYMBOL_BITS-1:0];
        end
        r_ss_qa <= r_ss[rd_a];
        r_ss_qb <= r_ss[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            r_ws[r_idx] <= tail_sel;
        end
        r_ws_qa <= r_ws[rd_a];
        r_ws_qb <= r_ws[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= NW'(1);
            r_k         <= kpg_pkg::PICK_W'(1);
            r_p         <= '0;
            r_carry     <= 1'b0;
            r_started   <= 1'b0;
            r_exhausted <= 1'b0;
            r_count     <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < DN; j++) begin
                r_digit[j] <= '0;
            end
        end else begin
            r_out_valid <= emit_dead || emit_sym;
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        case (i_req.kind)
                            kpg_pkg::REQ_RESTART: begin
                                r_n         <= i_run_n;
                                r_k         <= i_run_pick;
                                r_count     <= kpg_pkg::CNT_W'(1);
                                r_exhausted <= (i_run_n == NW'(1));
                                r_started   <= 1'b1;
                                r_wvalid    <= '0;
                                r_p         <= '0;
                                r_carry     <= 1'b1;
                                r_state     <= ST_READ;
                                for (int j = 0; j < DN; j++) begin
                                    r_digit[j] <= '0;
                                end
                            end
                            kpg_pkg::REQ_NEXT: begin
                                if (r_started && !r_exhausted) begin
                                    r_count     <= count_inc;
                                    r_exhausted <= &mx;
                                    r_wvalid    <= '0;
                                    r_p         <= '0;
                                    r_carry     <= 1'b1;
                                    r_state     <= ST_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_wvalid[r_idx] <= 1'b1;
                    if (r_carry) begin
                        if (wrap) begin
                            r_digit[r_p] <= '0;
                        end else begin
                            r_digit[r_p] <= IW'(d1);
                            r_carry      <= 1'b0;
                        end
                    end
                    if (at_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_p     <= r_p + PW'(1);
                        r_state <= ST_READ;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_idx  <= rd_a;
            r_tail <= rd_b;
        end
        if (emit_dead) begin
            r_out_sym  <= '0;
            r_out_last <= 1'b1;
            r_out_exh  <= 1'b1;
            r_out_cnt  <= r_count;
        end else if (emit_sym) begin
            r_out_sym  <= sym_wide[kpg_pkg::SYM_OUT_W-1:0];
            r_out_last <= at_last;
            r_out_exh  <= r_exhausted;
            r_out_cnt  <= r_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_symbol         = r_out_sym;
    assign o_last           = r_out_last;
    assign o_exhausted      = r_out_exh;
    assign o_produced_count = r_out_cnt;

endmodule

// ===== src/k_permutation_generator.sv =====
// top level of the k-permutation generator
// Usage: the command channel takes one request beat at a rising edge with start
// high and busy low. A load beat writes one symbol and gives no result. A restart
// beat takes element_count and pick_length as they stand, clears the digit counter,
// sets the count to one and the exhausted mark only for a one-element set, and
// emits the first selection; a next beat emits the following one, or a single
// exhausted beat when none is left or no restart came. Each result is shown for
// one cycle with o_valid high; the receiver cannot stall, so results are never
// held. Configuration beats use i_cfg_valid and o_cfg_ready, which is always high;
// write only while the block is idle. A two-entry queue parts the front from the
// back; busy is high only while it is full. The back handles loads and exhausted
// replies in its idle state and takes no request until a selection is finished;
// for each position of a selection it reads the symbol and working-set memories
// in the read state, then writes the swapped entry and emits its symbol in the
// write state. Reset is synchronous and active low; it restores the register
// defaults and clears the counter, flags and queue; the symbol memory is not
// cleared.
module k_permutation_generator #(
    parameter int MAX_ELEMENTS = kpg_pkg::DEF_MAX_ELEMENTS,
    parameter int SYMBOL_BITS  = kpg_pkg::DEF_SYMBOL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kpg_pkg::REQ_W-1:0]     i_req_type,
    input  logic [kpg_pkg::LIDX_W-1:0]    i_load_index,
    input  logic [kpg_pkg::LVAL_W-1:0]    i_load_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kpg_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [kpg_pkg::SYM_OUT_W-1:0] o_symbol,
    output logic                          o_last,
    output logic                          o_exhausted,
    output logic [kpg_pkg::CNT_W-1:0]     o_produced_count
);

    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam int QW = $bits(kpg_pkg::t_req) + NW + kpg_pkg::PICK_W;

    kpg_pkg::t_qstat            qstat;
    kpg_pkg::t_req              f_req;
    kpg_pkg::t_req              b_req;
    logic                       push;
    logic                       pop;
    logic [NW-1:0]              f_n;
    logic [NW-1:0]              b_n;
    logic [kpg_pkg::PICK_W-1:0] f_k;
    logic [kpg_pkg::PICK_W-1:0] b_k;
    logic [QW-1:0]              q_in;
    logic [QW-1:0]              q_out;

    assign o_cfg_ready = 1'b1;
    assign busy        = qstat.full;

    kpg_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req_type   (i_req_type),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_req        (f_req),
        .o_run_n      (f_n),
        .o_run_pick   (f_k)
    );

    assign q_in = {f_req, f_n, f_k};

    kpg_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_qstat (qstat)
    );

    assign {b_req, b_n, b_k} = q_out;

    kpg_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_qstat          (qstat),
        .i_req            (b_req),
        .i_run_n          (b_n),
        .i_run_pick       (b_k),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_symbol         (o_symbol),
        .o_last           (o_last),
        .o_exhausted      (o_exhausted),
        .o_produced_count (o_produced_count)
    );

`ifndef SYNTH
    a_beat_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> !o_valid ##1 o_valid)
        else $error("selection beats not spaced by one idle cycle");

    a_beat_status_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> ##1
            (o_produced_count == $past(o_produced_count, 2) &&
             o_exhausted == $past(o_exhausted, 2)))
        else $error("count or exhausted changed within a selection");

    a_emit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_exhausted |-> o_produced_count != 0)
        else $error("selection emitted with zero count");
`endif

endmodule
